@@ rtl/core/vtfo_pkg.sv @@
// Shared types and constants of the virtual-to-file-offset translator.
// Depends on nothing; every other file of the block but vtfo_ram imports it.
package vtfo_pkg;

   localparam int MAX_SECTIONS = 96;
   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   localparam logic ST_OK       = 1'b0;
   localparam logic ST_UNMAPPED = 1'b1;

   localparam int CSR_W = 2;
   localparam logic [CSR_W-1:0] CSR_HEADER_BYTES    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FILE_BYTES      = 2'd1;
   localparam logic [CSR_W-1:0] CSR_SECTIONS_IN_USE = 2'd2;

   // A table entry keeps the exclusive end of its span, worked out on write.
   typedef struct packed {
      logic [31:0] virtual_start;
      logic [32:0] virtual_end;
      logic [31:0] raw_length;
      logic [31:0] raw_start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic capture;
      logic head;
      logic scan;
      logic offs;
      logic check;
      logic miss;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic hdr_hit;
      logic entry_hit;
      logic scan_last;
      logic count_zero;
   } status_type;

endpackage

@@ rtl/core/vtfo_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module vtfo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic                                            rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/vtfo_ctrl.sv @@
// Sequencing state machine of the translator: handshakes and step commands.
// Depends on vtfo_pkg; drives vtfo_datapath through cmd_type.
module vtfo_ctrl
   import vtfo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_operation,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HEAD  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_OFFS  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_operation == OP_WRITE) ? S_FIN : S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head = 1'b1;
            if (status.hdr_hit) begin
               state_in = S_FIN;
            end else if (status.count_zero) begin
               cmd.miss = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.entry_hit) begin
               state_in = S_OFFS;
            end else if (status.scan_last) begin
               cmd.miss = 1'b1;
               state_in = S_FIN;
            end
         end
         S_OFFS: begin
            cmd.offs = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_scan_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !status.entry_hit && !status.scan_last) |=> state_ff == S_SCAN)
      else $error("section scan left early");

   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished word not presented");

   a_write_short: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && req_operation == OP_WRITE) |=> state_ff == S_FIN)
      else $error("write word did not go straight to finish");
`endif

endmodule

@@ rtl/core/vtfo_datapath.sv @@
// Datapath of the translator: configuration registers, section table,
// span compare, offset arithmetic and result register.
// Depends on vtfo_pkg and vtfo_ram; steered by vtfo_ctrl through cmd_type.
module vtfo_datapath
   import vtfo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_operation,
   input  logic [6:0]        req_entry_index,
   input  logic [31:0]       req_entry_virtual_start,
   input  logic [31:0]       req_entry_virtual_length,
   input  logic [31:0]       req_entry_raw_length,
   input  logic [31:0]       req_entry_raw_start,
   input  logic [31:0]       req_query_address,
   input  logic              csr_write,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [31:0]       csr_data,
   output logic              rsp_status,
   output logic [31:0]       rsp_file_offset,
   output logic [31:0]       rsp_bytes_available
);

   logic [31:0]      header_ff;
   logic [31:0]      file_ff;
   logic [6:0]       sections_ff;

   logic [31:0]      addr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_next;
   logic [31:0]      delta_ff;
   logic [31:0]      rl_ff;
   logic [31:0]      rs_ff;
   logic [32:0]      off_ff;
   logic [31:0]      x_ff;
   logic [31:0]      y_ff;
   logic             fail_ff;
   logic             fail_in;
   logic             zero_ff;

   logic             rsp_status_ff;
   logic [31:0]      rsp_file_offset_ff;
   logic [31:0]      rsp_bytes_available_ff;

   logic             wr_en;
   logic [31:0]      span;
   entry_type        wr_entry;
   entry_type        rd_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             hit;
   logic             last;
   logic [31:0]      avail;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff   <= '0;
         file_ff     <= '0;
         sections_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HEADER_BYTES:    header_ff   <= csr_data;
            CSR_FILE_BYTES:      file_ff     <= csr_data;
            CSR_SECTIONS_IN_USE: sections_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Table write: the span end is stored so the search needs only compares.
   assign span = (req_entry_virtual_length > req_entry_raw_length) ?
                 req_entry_virtual_length : req_entry_raw_length;
   assign wr_entry.virtual_start = req_entry_virtual_start;
   assign wr_entry.virtual_end   = {1'b0, req_entry_virtual_start} + {1'b0, span};
   assign wr_entry.raw_length    = req_entry_raw_length;
   assign wr_entry.raw_start     = req_entry_raw_start;
   assign wr_en = cmd.capture && (req_operation == OP_WRITE) &&
                  (32'(req_entry_index) < 32'(MAX_SECTIONS));

   assign idx_next = idx_ff + IDX_W'(1);
   assign last     = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign hit      = (addr_ff >= rd_entry.virtual_start) &&
                     ({1'b0, addr_ff} < rd_entry.virtual_end);
   assign rd_en    = cmd.head | (cmd.scan & !hit & !last);
   assign rd_addr  = cmd.scan ? idx_next : '0;

   vtfo_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SECTIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign count_in = (32'(sections_ff) > 32'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                           : CNT_W'(sections_ff);

   assign status.hdr_hit    = (addr_ff < header_ff) && (addr_ff < file_ff);
   assign status.count_zero = (count_in == '0);
   assign status.entry_hit  = hit;
   assign status.scan_last  = last;

   assign fail_in = fail_ff | cmd.miss |
                    (cmd.offs & (delta_ff >= rl_ff)) |
                    (cmd.check & (off_ff >= {1'b0, file_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else if (cmd.capture) begin
         fail_ff <= 1'b0;
         zero_ff <= (req_operation == OP_WRITE);
      end else begin
         fail_ff <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= req_query_address;
      end
      if (cmd.head) begin
         count_ff <= count_in;
         idx_ff   <= '0;
         off_ff   <= {1'b0, addr_ff};
         x_ff     <= header_ff - addr_ff;
         y_ff     <= file_ff - addr_ff;
      end
      if (cmd.scan) begin
         if (hit) begin
            delta_ff <= addr_ff - rd_entry.virtual_start;
            rl_ff    <= rd_entry.raw_length;
            rs_ff    <= rd_entry.raw_start;
         end else begin
            idx_ff <= idx_next;
         end
      end
      if (cmd.offs) begin
         off_ff <= {1'b0, rs_ff} + {1'b0, delta_ff};
         x_ff   <= rl_ff - delta_ff;
      end
      if (cmd.check) begin
         y_ff <= file_ff - off_ff[31:0];
      end
   end

   assign avail = (x_ff < y_ff) ? x_ff : y_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         priority if (zero_ff) begin
            rsp_status_ff          <= ST_OK;
            rsp_file_offset_ff     <= '0;
            rsp_bytes_available_ff <= '0;
         end else if (fail_ff) begin
            rsp_status_ff          <= ST_UNMAPPED;
            rsp_file_offset_ff     <= '0;
            rsp_bytes_available_ff <= '0;
         end else begin
            rsp_status_ff          <= ST_OK;
            rsp_file_offset_ff     <= off_ff[31:0];
            rsp_bytes_available_ff <= avail;
         end
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_file_offset     = rsp_file_offset_ff;
   assign rsp_bytes_available = rsp_bytes_available_ff;

`ifndef SYNTHESIS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond section count");

   a_write_word_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && zero_ff) |=>
      (rsp_status_ff == ST_OK && rsp_file_offset_ff == '0 && rsp_bytes_available_ff == '0))
      else $error("write word carries a non-zero result");

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (fail_ff && !cmd.capture) |=> fail_ff)
      else $error("not-mapped flag lost during a translation");
`endif

endmodule

@@ rtl/core/virtual_to_file_offset_translator.sv @@
// Top level of the virtual-to-file-offset translator.
// Depends on vtfo_pkg, vtfo_ctrl, vtfo_datapath and vtfo_ram.
//
//   Channel  Direction  Handshake          Word
//   req_     in         valid / stall      operation, section entry, query address
//   rsp_     out        valid / stall      status, file offset, bytes available
//   csr_     in         valid / ready      register index, write data
//
// A section write goes straight to finish; a header hit passes the header step first. Any
// other lookup then scans k table entries, one per cycle, k at most the section count
// (capped at 96); a hit adds offset and check steps before finish, a miss does not.
// Reset clears the state machine, the result valid and the configuration registers;
// the section table is not cleared. A stalled result waits in the output register
// while the next word is accepted and worked on; that word then waits until it is free.
module virtual_to_file_offset_translator
   import vtfo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [6:0]        req_entry_index,
   input  logic [31:0]       req_entry_virtual_start,
   input  logic [31:0]       req_entry_virtual_length,
   input  logic [31:0]       req_entry_raw_length,
   input  logic [31:0]       req_entry_raw_start,
   input  logic [31:0]       req_query_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status,
   output logic [31:0]       rsp_file_offset,
   output logic [31:0]       rsp_bytes_available,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [31:0]       csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   vtfo_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   vtfo_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_operation            (req_operation),
      .req_entry_index          (req_entry_index),
      .req_entry_virtual_start  (req_entry_virtual_start),
      .req_entry_virtual_length (req_entry_virtual_length),
      .req_entry_raw_length     (req_entry_raw_length),
      .req_entry_raw_start      (req_entry_raw_start),
      .req_query_address        (req_query_address),
      .csr_write                (csr_valid & csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .rsp_status               (rsp_status),
      .rsp_file_offset          (rsp_file_offset),
      .rsp_bytes_available      (rsp_bytes_available)
   );

endmodule

@@ tb/virtual_to_file_offset_translator_tb.sv @@
// Testbench for the virtual-to-file-offset translator: directed and random section writes
// and address lookups, checked word by word against a behavioural predictor of the block.
// Depends on vtfo_pkg and the virtual_to_file_offset_translator RTL.
module virtual_to_file_offset_translator_tb
   import vtfo_pkg::*;
;

   typedef struct {
      logic        op;
      logic [6:0]  slot;
      logic [31:0] vstart;
      logic [31:0] vlen;
      logic [31:0] rlen;
      logic [31:0] rstart;
      logic [31:0] addr;
   } section_word_type;

   typedef struct {
      logic        status;
      logic [31:0] offset;
      logic [31:0] avail;
   } lookup_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_operation = OP_WRITE;
   logic [6:0]       req_entry_index = 7'd0;
   logic [31:0]      req_entry_virtual_start = 32'd0;
   logic [31:0]      req_entry_virtual_length = 32'd0;
   logic [31:0]      req_entry_raw_length = 32'd0;
   logic [31:0]      req_entry_raw_start = 32'd0;
   logic [31:0]      req_query_address = 32'd0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_status;
   logic [31:0]      rsp_file_offset;
   logic [31:0]      rsp_bytes_available;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_index = CSR_HEADER_BYTES;
   logic [31:0]      csr_data = 32'd0;

   logic [31:0] header_size = 32'd0;
   logic [31:0] file_size = 32'd0;
   logic [6:0]  search_count = 7'd0;
   logic [31:0] sec_vstart [MAX_SECTIONS];
   logic [31:0] sec_vlen [MAX_SECTIONS];
   logic [31:0] sec_rlen [MAX_SECTIONS];
   logic [31:0] sec_rstart [MAX_SECTIONS];
   bit          loaded [MAX_SECTIONS];

   lookup_result_type pending_results[$];
   int          failures = 0;
   bit          steady = 1'b0;

   virtual_to_file_offset_translator dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_operation            (req_operation),
      .req_entry_index          (req_entry_index),
      .req_entry_virtual_start  (req_entry_virtual_start),
      .req_entry_virtual_length (req_entry_virtual_length),
      .req_entry_raw_length     (req_entry_raw_length),
      .req_entry_raw_start      (req_entry_raw_start),
      .req_query_address        (req_query_address),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_file_offset          (rsp_file_offset),
      .rsp_bytes_available      (rsp_bytes_available),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("virtual_to_file_offset_translator_tb NOT OK");
      $finish;
   end

   function automatic lookup_result_type translate_address(logic [31:0] addr);
      lookup_result_type r;
      logic [31:0]    span;
      logic [31:0]    delta;
      logic [32:0]    offs;
      int             reach;
      r = '{ST_UNMAPPED, 32'd0, 32'd0};
      if (addr < header_size && addr < file_size) begin
         r.status = ST_OK;
         r.offset = addr;
         r.avail = (header_size - addr < file_size - addr) ? header_size - addr
                                                           : file_size - addr;
         return r;
      end
      reach = (search_count > MAX_SECTIONS) ? MAX_SECTIONS : search_count;
      for (int i = 0; i < reach; i++) begin
         span = (sec_vlen[i] > sec_rlen[i]) ? sec_vlen[i] : sec_rlen[i];
         delta = addr - sec_vstart[i];
         if (addr >= sec_vstart[i] && delta < span) begin
            offs = {1'b0, sec_rstart[i]} + {1'b0, delta};
            if (delta < sec_rlen[i] && offs < {1'b0, file_size}) begin
               r.status = ST_OK;
               r.offset = offs[31:0];
               r.avail = (sec_rlen[i] - delta < file_size - offs[31:0]) ?
                         sec_rlen[i] - delta : file_size - offs[31:0];
            end
            return r;
         end
      end
      return r;
   endfunction

   task automatic record_word(section_word_type w);
      if (w.op == OP_WRITE) begin
         if (w.slot < MAX_SECTIONS) begin
            sec_vstart[w.slot] = w.vstart;
            sec_vlen[w.slot] = w.vlen;
            sec_rlen[w.slot] = w.rlen;
            sec_rstart[w.slot] = w.rstart;
            loaded[w.slot] = 1'b1;
         end
         pending_results.push_back('{ST_OK, 32'd0, 32'd0});
      end else begin
         pending_results.push_back(translate_address(w.addr));
      end
   endtask

   task automatic send_word(section_word_type w);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= w.op;
      req_entry_index <= w.slot;
      req_entry_virtual_start <= w.vstart;
      req_entry_virtual_length <= w.vlen;
      req_entry_raw_length <= w.rlen;
      req_entry_raw_start <= w.rstart;
      req_query_address <= w.addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      record_word(w);
   endtask

   task automatic send_write(logic [6:0] slot, logic [31:0] vs, logic [31:0] vl,
                             logic [31:0] rl, logic [31:0] rs);
      send_word('{OP_WRITE, slot, vs, vl, rl, rs, $urandom()});
   endtask

   task automatic send_query(logic [31:0] addr);
      send_word('{OP_TRANSLATE, 7'($urandom()), $urandom(), $urandom(), $urandom(),
                  $urandom(), addr});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] hdr, logic [31:0] fsz, logic [6:0] cnt);
      logic [31:0]      vals [3];
      logic [CSR_W-1:0] regs [3];
      vals = '{hdr, fsz, {25'd0, cnt}};
      regs = '{CSR_HEADER_BYTES, CSR_FILE_BYTES, CSR_SECTIONS_IN_USE};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[k];
         csr_data <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      header_size = hdr;
      file_size = fsz;
      search_count = cnt;
   endtask

   function automatic logic [31:0] random_length();
      case ($urandom_range(4))
         0: return 32'd0;
         1, 2: return $urandom_range(4096);
         3: return $urandom();
         default: return 32'hFFFF_FFFF - $urandom_range(15);
      endcase
   endfunction

   function automatic section_word_type random_entry(logic [6:0] slot);
      section_word_type w;
      int            j;
      w.op = OP_WRITE;
      w.slot = slot;
      w.vstart = $urandom();
      w.vlen = random_length();
      w.rlen = random_length();
      w.rstart = ($urandom_range(1) != 0) ? $urandom_range(file_size, 0) : $urandom();
      w.addr = $urandom();
      j = $urandom_range(MAX_SECTIONS - 1);
      if ($urandom_range(9) == 0 && loaded[j])
         w.vstart = sec_vstart[j];
      return w;
   endfunction

   function automatic logic [31:0] random_address();
      int unsigned pick;
      int          reach;
      int          k;
      logic [31:0] lo;
      logic [31:0] vs;
      logic [31:0] span;
      reach = (search_count > MAX_SECTIONS) ? MAX_SECTIONS : search_count;
      lo = (header_size < file_size) ? header_size : file_size;
      pick = $urandom_range(99);
      if (pick < 25 && lo != 0) begin
         case ($urandom_range(3))
            0: return 32'd0;
            1: return lo - 1;
            2: return lo;
            default: return $urandom_range(lo - 1, 0);
         endcase
      end
      if (pick < 80 && reach != 0) begin
         k = $urandom_range(reach - 1);
         vs = sec_vstart[k];
         span = (sec_vlen[k] > sec_rlen[k]) ? sec_vlen[k] : sec_rlen[k];
         case ($urandom_range(5))
            0: return vs;
            1: return vs + sec_rlen[k] - 1;
            2: return vs + sec_rlen[k];
            3: return vs + span - 1;
            4: return vs + span;
            default: return vs + $urandom_range(span);
         endcase
      end
      return $urandom();
   endfunction

   // Header region, with the file shorter than the header and the other way round.
   task automatic test_header_region();
      configure(32'h1000, 32'h800, 7'd0);
      send_query(32'h0);
      send_query(32'h7FF);
      send_query(32'h800);
      drain();
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0);
      send_query(32'h0);
      send_query(32'hFFFF_FFFE);
      send_query(32'hFFFF_FFFF);
      drain();
      configure(32'h200, 32'h10000, 7'd0);
      send_query(32'h1FF);
      send_query(32'h200);
      drain();
      configure(32'h0, 32'h0, 7'd0);
      send_query(32'h0);
   endtask

   // Overlapping sections, a delta past the raw length, an offset past the file, an offset
   // that carries out of 32 bits, a section at the top of the address space and writes to
   // slots beyond the table.
   task automatic test_section_search();
      send_write(7'd0, 32'h1000, 32'h2000, 32'h800, 32'h400);
      send_write(7'd1, 32'h1800, 32'h100, 32'h100, 32'h9000);
      send_write(7'd2, 32'h10000, 32'h0, 32'h1000, 32'hFFFF_F800);
      send_write(7'd3, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h100, 32'h0);
      send_write(7'd127, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_write(7'd96, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      drain();
      configure(32'h400, 32'hFFFF_F900, 7'd4);
      send_query(32'h3FF);
      send_query(32'h1000);
      send_query(32'h17FF);
      send_query(32'h1800);
      send_query(32'h3000);
      send_query(32'h10000);
      send_query(32'h10100);
      send_query(32'h10FFF);
      send_query(32'hFFFF_FFFF);
      send_query(32'hFFFF_FF00);
   endtask

   // Every slot loaded, then a full count and a count beyond the table size.
   task automatic test_full_table();
      for (int s = 0; s < MAX_SECTIONS; s++)
         send_word(random_entry(7'(s)));
      drain();
      configure(32'h100, 32'hFFFF_FFFF, 7'd96);
      repeat (6) send_query(random_address());
      drain();
      configure(32'h100, 32'hFFFF_F000, 7'd127);
      repeat (6) send_query(random_address());
   endtask

   task automatic test_random_traffic();
      logic [6:0] slot;
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: configure($urandom_range(32'h1000), 32'hFFFF_FFFF, 7'd96);
            1: configure(32'hFFFF_FFFF, $urandom(), 7'($urandom_range(96, 1)));
            2: configure($urandom(), $urandom(), 7'd127);
            3: configure(32'h0, $urandom(), 7'($urandom_range(127)));
            default: configure($urandom(), 32'h0, 7'($urandom_range(127, 97)));
         endcase
         steady = (phase == 2);
         for (int n = 0; n < 245; n++) begin
            if ($urandom_range(3) == 0) begin
               slot = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 96))
                                               : 7'($urandom_range(95));
               send_word(random_entry(slot));
            end else begin
               send_query(random_address());
            end
         end
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin : result_check
      lookup_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result word arrived with none outstanding");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0h actual %0h", want.status, rsp_status);
               failures++;
            end
            if (rsp_file_offset !== want.offset) begin
               $error("file_offset expected %0h actual %0h", want.offset, rsp_file_offset);
               failures++;
            end
            if (rsp_bytes_available !== want.avail) begin
               $error("bytes_available expected %0h actual %0h", want.avail,
                      rsp_bytes_available);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_header_region();
      test_section_search();
      test_full_table();
      test_random_traffic();
      drain();
      repeat (120) @(posedge clock);
      if (failures == 0)
         $display("virtual_to_file_offset_translator_tb OK");
      else
         $display("virtual_to_file_offset_translator_tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/vtfo_pkg.sv
rtl/core/vtfo_ram.sv
rtl/core/vtfo_ctrl.sv
rtl/core/vtfo_datapath.sv
rtl/core/virtual_to_file_offset_translator.sv
tb/virtual_to_file_offset_translator_tb.sv
